### src/swodo_pkg.sv
// ----------------------------------------------------------------------------
// swodo_pkg
// Shared types, constants and helper functions of the swerve odometry core.
// ----------------------------------------------------------------------------
package swodo_pkg;

   localparam int STEER_BITS        = 12;
   localparam int NUM_INPUTS        = 4;
   localparam int NUM_WHEELS_DEF    = 4;
   localparam int POS_FRAC_BITS_DEF = 16;
   localparam int CORDIC_STEPS      = 14;
   localparam int CORDIC_START      = 39797;
   localparam int CSR_IDX_BITS      = 3;
   localparam int CSR_DATA_BITS     = 20;
   localparam int QUEUE_DEPTH       = 2;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_BITS-1:0] CSR_SPEED_SCALE = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_STEP_TIME   = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_INV_STEP    = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_HALF_LENGTH = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_HALF_WIDTH  = 3'd4;

   localparam logic [15:0] SPEED_SCALE_RST = 16'd9781;
   localparam logic [15:0] STEP_TIME_RST   = 16'd328;
   localparam logic [15:0] INV_STEP_RST    = 16'd200;
   localparam logic [19:0] HALF_LENGTH_RST = 20'd27001;
   localparam logic [19:0] HALF_WIDTH_RST  = 20'd29950;

   typedef struct packed {
      logic signed [15:0]     speed_0;
      logic signed [15:0]     speed_1;
      logic signed [15:0]     speed_2;
      logic signed [15:0]     speed_3;
      logic [STEER_BITS-1:0]  steer_0;
      logic [STEER_BITS-1:0]  steer_1;
      logic [STEER_BITS-1:0]  steer_2;
      logic [STEER_BITS-1:0]  steer_3;
      logic signed [15:0]     yaw_sample;
   } req_type;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
      logic signed [15:0] yaw_out;
      logic signed [31:0] angular_rate;
   } rsp_type;

   typedef struct packed {
      logic [15:0] speed_scale;
      logic [15:0] step_time;
      logic [15:0] inverse_step_time;
      logic [19:0] half_length;
      logic [19:0] half_width;
   } cfg_type;

   // One classified tick handed from the front to the back.
   typedef struct packed {
      logic [NUM_INPUTS-1:0][15:0] speed;
      logic [NUM_INPUTS-1:0][15:0] head;
      logic [15:0]                 yaw_rel;
      logic signed [31:0]          rate;
      logic                        first;
   } job_type;

   function automatic logic [13:0] atan_entry(input logic [3:0] step);
      logic [13:0] v;
      case (step)
         4'd0:    v = 14'd8192;
         4'd1:    v = 14'd4836;
         4'd2:    v = 14'd2555;
         4'd3:    v = 14'd1297;
         4'd4:    v = 14'd651;
         4'd5:    v = 14'd326;
         4'd6:    v = 14'd163;
         4'd7:    v = 14'd81;
         4'd8:    v = 14'd41;
         4'd9:    v = 14'd20;
         4'd10:   v = 14'd10;
         4'd11:   v = 14'd5;
         4'd12:   v = 14'd3;
         4'd13:   v = 14'd1;
         default: v = 14'd0;
      endcase
      return v;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > 64'sd2147483647) begin
         r = 32'sh7FFFFFFF;
      end else if (v < -64'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

### src/swodo_front.sv
// ----------------------------------------------------------------------------
// swodo_front
// Accepts ticks, tracks the yaw offset and computes headings and yaw rate.
// ----------------------------------------------------------------------------
module swodo_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  swodo_pkg::req_type req_data,
   input  swodo_pkg::cfg_type cfg,
   input  logic              queue_full,
   output logic              push,
   output swodo_pkg::job_type job
);
   import swodo_pkg::*;

   localparam logic [STEER_BITS-1:0] STEER_MID = STEER_BITS'(1) << (STEER_BITS - 1);

   logic                    taken_ff, taken_in;
   logic [15:0]             offset_ff, offset_in;
   logic [15:0]             prev_ff, prev_in;
   logic [15:0]             yaw_base;
   logic [15:0]             yaw_rel;
   logic signed [15:0]      dyaw;
   logic signed [32:0]      rate_full;
   logic [NUM_INPUTS-1:0][STEER_BITS-1:0] codes;
   logic [NUM_INPUTS-1:0][15:0] heads;

   assign req_ready = !queue_full;
   assign push      = req_valid && req_ready;

   assign yaw_base  = taken_ff ? offset_ff : req_data.yaw_sample;
   assign yaw_rel   = req_data.yaw_sample - yaw_base;
   assign dyaw      = $signed(yaw_rel - prev_ff);
   assign rate_full = dyaw * $signed({1'b0, cfg.inverse_step_time});

   assign codes[0] = req_data.steer_0;
   assign codes[1] = req_data.steer_1;
   assign codes[2] = req_data.steer_2;
   assign codes[3] = req_data.steer_3;

   always_comb begin
      for (int i = 0; i < NUM_INPUTS; i++) begin
         heads[i] = (16'(codes[i] - STEER_MID) << (16 - STEER_BITS)) + yaw_rel;
      end
   end

   always_comb begin
      job.speed[0] = req_data.speed_0;
      job.speed[1] = req_data.speed_1;
      job.speed[2] = req_data.speed_2;
      job.speed[3] = req_data.speed_3;
      job.head     = heads;
      job.yaw_rel  = yaw_rel;
      job.rate     = rate_full[31:0];
      job.first    = !taken_ff;
   end

   always_comb begin
      taken_in  = taken_ff;
      offset_in = offset_ff;
      prev_in   = prev_ff;
      if (push) begin
         taken_in  = 1'b1;
         offset_in = yaw_base;
         prev_in   = yaw_rel;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         taken_ff  <= 1'b0;
         offset_ff <= '0;
         prev_ff   <= '0;
      end else begin
         taken_ff  <= taken_in;
         offset_ff <= offset_in;
         prev_ff   <= prev_in;
      end
   end

endmodule

### src/swodo_queue.sv
// ----------------------------------------------------------------------------
// swodo_queue
// Short queue of classified ticks between the front and the back.
// ----------------------------------------------------------------------------
module swodo_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  swodo_pkg::job_type push_data,
   input  logic               pop,
   output logic               full,
   output logic               empty,
   output swodo_pkg::job_type pop_data
);
   import swodo_pkg::*;

   localparam int PW = $clog2(QUEUE_DEPTH);

   job_type          mem_ff [QUEUE_DEPTH];
   logic [PW-1:0]    wr_ff, wr_in;
   logic [PW-1:0]    rd_ff, rd_in;
   logic [PW:0]      cnt_ff, cnt_in;

   assign full     = cnt_ff == (PW+1)'(QUEUE_DEPTH);
   assign empty    = cnt_ff == '0;
   assign pop_data = mem_ff[rd_ff];

   always_comb begin
      wr_in  = push ? PW'(wr_ff + 1'b1) : wr_ff;
      rd_in  = pop ? PW'(rd_ff + 1'b1) : rd_ff;
      cnt_in = cnt_ff + (PW+1)'(push) - (PW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

### src/swodo_back.sv
// ----------------------------------------------------------------------------
// swodo_back
// Rotates, scales and integrates each wheel in turn, then averages.
// ----------------------------------------------------------------------------
module swodo_back #(
   parameter int NUM_WHEELS    = swodo_pkg::NUM_WHEELS_DEF,
   parameter int POS_FRAC_BITS = swodo_pkg::POS_FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  swodo_pkg::cfg_type cfg,
   input  logic               queue_empty,
   input  swodo_pkg::job_type job,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output swodo_pkg::rsp_type rsp_data
);
   import swodo_pkg::*;

   localparam int WW  = (NUM_WHEELS > 2) ? $clog2(NUM_WHEELS) : 1;
   localparam int VW  = POS_FRAC_BITS + 10;
   localparam int PW  = (VW + 2 > 34) ? VW + 2 : 34;
   localparam int SW  = (VW + 3 > 35) ? VW + 3 : 35;
   localparam int RW  = $clog2(NUM_WHEELS) + 1;
   localparam int DCW = 1;
   localparam int CW  = 20;
   localparam int ZW  = 18;
   localparam int VSH = 40 - POS_FRAC_BITS;

   // The mean is divided in two digits by reciprocal multiplication. The
   // shifts are chosen so that the quotient is exact for up to eight wheels.
   localparam int LOW = 17;
   localparam int HIW = SW - LOW;
   localparam int S1  = HIW + 3;
   localparam int S2  = LOW + 6;
   localparam logic [S1-1:0] R1 =
      S1'(((64'd1 << S1) + 64'(NUM_WHEELS) - 64'd1) / 64'(NUM_WHEELS));
   localparam logic [S2-1:0] R2 =
      S2'(((64'd1 << S2) + 64'(NUM_WHEELS) - 64'd1) / 64'(NUM_WHEELS));

   typedef enum logic [9:0] {
      ST_IDLE = 10'b0000000001,
      ST_LOAD = 10'b0000000010,
      ST_ROT  = 10'b0000000100,
      ST_MUL1 = 10'b0000001000,
      ST_MUL2 = 10'b0000010000,
      ST_MUL3 = 10'b0000100000,
      ST_UPD  = 10'b0001000000,
      ST_PREP = 10'b0010000000,
      ST_DIV  = 10'b0100000000,
      ST_DONE = 10'b1000000000
   } state_type;

   state_type               state_ff, state_in;
   job_type                 job_ff, job_in;
   logic [WW-1:0]           wheel_ff, wheel_in;
   logic [3:0]              iter_ff, iter_in;
   logic [DCW-1:0]          dcnt_ff, dcnt_in;
   logic signed [CW-1:0]    cx_ff, cx_in, cy_ff, cy_in;
   logic signed [ZW-1:0]    cz_ff, cz_in;
   logic                    flip_ff, flip_in;
   logic signed [35:0]      pa_ff, pa_in, pb_ff, pb_in;
   logic signed [VW-1:0]    vx_ff, vx_in, vy_ff, vy_in;
   logic signed [VW:0]      dx_ff, dx_in, dy_ff, dy_in;
   logic signed [31:0]      px_ff [NUM_WHEELS];
   logic signed [31:0]      px_in [NUM_WHEELS];
   logic signed [31:0]      py_ff [NUM_WHEELS];
   logic signed [31:0]      py_in [NUM_WHEELS];
   logic [3:0][SW-1:0]      acc_ff, acc_in;
   logic [3:0]              neg_ff, neg_in;
   logic [3:0][RW-1:0]      rem_ff, rem_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_ff, rsp_in;

   logic [2:0]              wheel_ext;
   logic [1:0]              sel;
   logic signed [15:0]      spd;
   logic signed [ZW-1:0]    h;
   logic signed [CW-1:0]    shx, shy, cval, sval;
   logic signed [ZW-1:0]    atan_s;
   logic signed [52:0]      mx, my;
   logic signed [VW+16:0]   ix, iy;
   logic signed [PW-1:0]    nx, ny;
   logic signed [31:0]      qx, qy;
   logic signed [31:0]      hl, hw;
   logic [HIW-1:0]          dhi, dq1;
   logic [HIW+S1-1:0]       dp1;
   logic [RW+LOW-1:0]       dm2;
   logic [RW+LOW+S2-1:0]    dp2;
   logic signed [SW-1:0]    quo;
   logic signed [31:0]      mean [4];
   logic                    out_free;

   assign wheel_ext = 3'(wheel_ff);
   assign sel       = wheel_ext[1:0];
   assign spd       = $signed(job_ff.speed[sel]);
   assign h         = ZW'($signed(job_ff.head[sel]));
   assign shx       = cy_ff >>> iter_ff;
   assign shy       = cx_ff >>> iter_ff;
   assign atan_s    = ZW'($signed({1'b0, atan_entry(iter_ff)}));
   assign cval      = flip_ff ? -cx_ff : cx_ff;
   assign sval      = flip_ff ? -cy_ff : cy_ff;
   assign mx        = pa_ff * $signed({1'b0, cfg.speed_scale});
   assign my        = pb_ff * $signed({1'b0, cfg.speed_scale});
   assign ix        = vx_ff * $signed({1'b0, cfg.step_time});
   assign iy        = vy_ff * $signed({1'b0, cfg.step_time});
   assign nx        = PW'(px_ff[wheel_ff]) + PW'(dx_ff);
   assign ny        = PW'(py_ff[wheel_ff]) + PW'(dy_ff);
   assign qx        = sat32(64'(nx));
   assign qy        = sat32(64'(ny));
   assign hl        = $signed({12'd0, cfg.half_length});
   assign hw        = $signed({12'd0, cfg.half_width});
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign pop       = (state_ff == ST_IDLE) && !queue_empty;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         quo     = $signed(acc_ff[k]);
         quo     = neg_ff[k] ? -quo : quo;
         mean[k] = sat32(64'(quo));
      end
   end

   always_comb begin
      state_in     = state_ff;
      job_in       = job_ff;
      wheel_in     = wheel_ff;
      iter_in      = iter_ff;
      dcnt_in      = dcnt_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      cz_in        = cz_ff;
      flip_in      = flip_ff;
      pa_in        = pa_ff;
      pb_in        = pb_ff;
      vx_in        = vx_ff;
      vy_in        = vy_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      px_in        = px_ff;
      py_in        = py_ff;
      acc_in       = acc_ff;
      neg_in       = neg_ff;
      rem_in       = rem_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      dhi          = '0;
      dq1          = '0;
      dp1          = '0;
      dm2          = '0;
      dp2          = '0;
      case (state_ff)
         ST_IDLE: begin
            if (!queue_empty) begin
               job_in   = job;
               wheel_in = '0;
               acc_in   = '0;
               if (job.first) begin
                  // Corner pattern repeats every four wheels.
                  for (int i = 0; i < NUM_WHEELS; i++) begin
                     px_in[i] = ((i % 4 == 0) || (i % 4 == 3)) ? hl : -hl;
                     py_in[i] = (i % 4 < 2) ? hw : -hw;
                  end
               end
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            cx_in   = CW'(CORDIC_START);
            cy_in   = '0;
            iter_in = '0;
            if (h > 18'sd16384) begin
               cz_in   = h - 18'sd32768;
               flip_in = 1'b1;
            end else if (h < -18'sd16384) begin
               cz_in   = h + 18'sd32768;
               flip_in = 1'b1;
            end else begin
               cz_in   = h;
               flip_in = 1'b0;
            end
            state_in = ST_ROT;
         end
         ST_ROT: begin
            if (cz_ff >= 0) begin
               cx_in = cx_ff - shx;
               cy_in = cy_ff + shy;
               cz_in = cz_ff - atan_s;
            end else begin
               cx_in = cx_ff + shx;
               cy_in = cy_ff - shy;
               cz_in = cz_ff + atan_s;
            end
            iter_in = iter_ff + 4'd1;
            if (iter_ff == 4'(CORDIC_STEPS - 1)) begin
               state_in = ST_MUL1;
            end
         end
         ST_MUL1: begin
            pa_in    = spd * cval;
            pb_in    = spd * sval;
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            vx_in    = VW'(mx >>> VSH);
            vy_in    = VW'(my >>> VSH);
            state_in = ST_MUL3;
         end
         ST_MUL3: begin
            dx_in    = (VW+1)'(ix >>> 16);
            dy_in    = (VW+1)'(iy >>> 16);
            state_in = ST_UPD;
         end
         ST_UPD: begin
            px_in[wheel_ff] = qx;
            py_in[wheel_ff] = qy;
            acc_in[0] = acc_ff[0] + SW'(qx);
            acc_in[1] = acc_ff[1] + SW'(qy);
            acc_in[2] = acc_ff[2] + SW'(vx_ff);
            acc_in[3] = acc_ff[3] + SW'(vy_ff);
            if (wheel_ff == WW'(NUM_WHEELS - 1)) begin
               state_in = ST_PREP;
            end else begin
               wheel_in = wheel_ff + 1'b1;
               state_in = ST_LOAD;
            end
         end
         ST_PREP: begin
            // Divide magnitudes so that the mean truncates toward zero.
            for (int k = 0; k < 4; k++) begin
               neg_in[k] = acc_ff[k][SW-1];
               acc_in[k] = acc_ff[k][SW-1] ? -acc_ff[k] : acc_ff[k];
               rem_in[k] = '0;
            end
            dcnt_in  = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            // The first pass divides the upper part and keeps its remainder, the
            // second divides the remainder joined with the lower part.
            for (int k = 0; k < 4; k++) begin
               if (dcnt_ff == 1'b0) begin
                  dhi       = acc_ff[k][SW-1:LOW];
                  dp1       = (HIW+S1)'(dhi) * (HIW+S1)'(R1);
                  dq1       = HIW'(dp1 >> S1);
                  rem_in[k] = RW'(dhi - HIW'(dq1 * HIW'(NUM_WHEELS)));
                  acc_in[k] = {dq1, acc_ff[k][LOW-1:0]};
               end else begin
                  dm2       = {rem_ff[k], acc_ff[k][LOW-1:0]};
                  dp2       = (RW+LOW+S2)'(dm2) * (RW+LOW+S2)'(R2);
                  acc_in[k] = {acc_ff[k][SW-1:LOW], LOW'(0)} + SW'(dp2 >> S2);
               end
            end
            dcnt_in = dcnt_ff + 1'b1;
            if (dcnt_ff == 1'b1) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_in.pos_x        = mean[0];
               rsp_in.pos_y        = mean[1];
               rsp_in.vel_x        = mean[2];
               rsp_in.vel_y        = mean[3];
               rsp_in.yaw_out      = $signed(job_ff.yaw_rel);
               rsp_in.angular_rate = job_ff.rate;
               rsp_valid_in        = 1'b1;
               state_in            = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      job_ff  <= job_in;
      iter_ff <= iter_in;
      dcnt_ff <= dcnt_in;
      cx_ff   <= cx_in;
      cy_ff   <= cy_in;
      cz_ff   <= cz_in;
      flip_ff <= flip_in;
      pa_ff   <= pa_in;
      pb_ff   <= pb_in;
      vx_ff   <= vx_in;
      vy_ff   <= vy_in;
      dx_ff   <= dx_in;
      dy_ff   <= dy_in;
      px_ff   <= px_in;
      py_ff   <= py_in;
      acc_ff  <= acc_in;
      neg_ff  <= neg_in;
      rem_ff  <= rem_in;
      rsp_ff  <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wheel_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wheel_ff     <= wheel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_wheel_range: assert property (@(posedge clock) disable iff (reset)
      wheel_ff <= WW'(NUM_WHEELS - 1))
      else $error("wheel counter beyond last wheel");

   a_rot_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ROT |-> iter_ff < 4'(CORDIC_STEPS))
      else $error("rotation ran past its last step");

   a_done_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && out_free) |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("finished tick did not reach the output register");

   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      pop |=> state_ff == ST_LOAD)
      else $error("popped tick was not started");

endmodule

### src/swerve_wheel_odometry_core.sv
// ----------------------------------------------------------------------------
// swerve_wheel_odometry_core
// Dead-reckoning odometry for a vehicle with independently steered wheels.
// ----------------------------------------------------------------------------
// Each req_ transaction carries four wheel speeds, four steering codes and an
// absolute yaw sample; each rsp_ transaction returns the mean wheel position,
// the mean velocity, the yaw relative to the first sample and the yaw rate.
// The user must write the five csr_ settings only while the core is idle; the
// core itself does not enforce this. A front stage takes the transaction,
// fixes the yaw offset on the first one, forms the headings and the yaw rate,
// and pushes the result into a two-entry queue. The back stage pulls one entry
// at a time and works through the wheels on one shared rotation unit and one
// set of multipliers: per wheel a load, 14 rotation steps, three multiply
// stages and an update, then a step that takes magnitudes and a two-digit
// reciprocal division for the means. Reset clears the yaw offset, the queue
// and the back state; wheel corners are loaded by the first transaction after
// reset. When the receiver stalls the result holds in the output register, the
// back finishes the next transaction and waits, and the front keeps accepting
// until the queue fills.
// ----------------------------------------------------------------------------
module swerve_wheel_odometry_core #(
   parameter int NUM_WHEELS    = swodo_pkg::NUM_WHEELS_DEF,
   parameter int POS_FRAC_BITS = swodo_pkg::POS_FRAC_BITS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  swodo_pkg::req_type                    req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output swodo_pkg::rsp_type                    rsp_data,
   input  logic                                  csr_write_enable,
   input  logic [swodo_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [swodo_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);
   import swodo_pkg::*;

   cfg_type cfg_ff, cfg_in;
   job_type front_job, queue_job;
   logic    push, pop, queue_full, queue_empty;

   // Configuration registers; writes to unknown indexes are dropped.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_SPEED_SCALE: cfg_in.speed_scale       = csr_wdata[15:0];
            CSR_STEP_TIME:   cfg_in.step_time         = csr_wdata[15:0];
            CSR_INV_STEP:    cfg_in.inverse_step_time = csr_wdata[15:0];
            CSR_HALF_LENGTH: cfg_in.half_length       = csr_wdata[19:0];
            CSR_HALF_WIDTH:  cfg_in.half_width        = csr_wdata[19:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.speed_scale       <= SPEED_SCALE_RST;
         cfg_ff.step_time         <= STEP_TIME_RST;
         cfg_ff.inverse_step_time <= INV_STEP_RST;
         cfg_ff.half_length       <= HALF_LENGTH_RST;
         cfg_ff.half_width        <= HALF_WIDTH_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   swodo_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .cfg        (cfg_ff),
      .queue_full (queue_full),
      .push       (push),
      .job        (front_job)
   );

   swodo_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (front_job),
      .pop       (pop),
      .full      (queue_full),
      .empty     (queue_empty),
      .pop_data  (queue_job)
   );

   swodo_back #(
      .NUM_WHEELS    (NUM_WHEELS),
      .POS_FRAC_BITS (POS_FRAC_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .queue_empty (queue_empty),
      .job         (queue_job),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

endmodule

### tb/sv/swerve_wheel_odometry_checker.sv
// ----------------------------------------------------------------------------
// swerve_wheel_odometry_checker
// Watches the odometry core's channels, predicts each result and compares.
// ----------------------------------------------------------------------------
// Settings are tracked from the csr_ port, every accepted req_ transaction is
// run through a fixed-point odometry model and the outcome is queued. Each
// accepted rsp_ transaction is compared field by field with the oldest entry.
// ----------------------------------------------------------------------------
module swerve_wheel_odometry_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  swodo_pkg::req_type                  req_data,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  swodo_pkg::rsp_type                  rsp_data,
   input  logic                                csr_write_enable,
   input  logic [swodo_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [swodo_pkg::CSR_DATA_BITS-1:0] csr_wdata,
   output int                                  fail_count,
   output int                                  outstanding,
   output int                                  checked_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import swodo_pkg::*;

   localparam int WHEELS = 4;
   localparam int ROT_STEPS = 14;
   localparam int ROT_GAIN = 39797;
   localparam int ARC_STEP [ROT_STEPS] = '{8192, 4836, 2555, 1297, 651, 326, 163,
                                          81, 41, 20, 10, 5, 3, 1};

   cfg_type            settings;
   logic signed [31:0] corner_x [WHEELS];
   logic signed [31:0] corner_y [WHEELS];
   logic [15:0]        yaw_zero;
   logic [15:0]        last_yaw;
   bit                 zero_taken;
   rsp_type            pending_odometry [$];

   assign outstanding = pending_odometry.size();

   function automatic logic signed [31:0] clamp32(input longint v);
      if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   // Shift-add rotation of a unit vector; the half turn is folded first.
   function automatic void rotate_heading(input int angle, output longint c,
                                          output longint s);
      longint x, y, dx, dy;
      int     z;
      bit     flip;
      x = ROT_GAIN;
      y = 0;
      z = angle;
      flip = 0;
      if (z > 16384) begin
         z -= 32768;
         flip = 1;
      end else if (z < -16384) begin
         z += 32768;
         flip = 1;
      end
      for (int i = 0; i < ROT_STEPS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx; y += dy; z -= ARC_STEP[i];
         end else begin
            x += dx; y -= dy; z += ARC_STEP[i];
         end
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
   endfunction

   function automatic rsp_type advance_odometry(input req_type t);
      logic signed [15:0] spd [WHEELS];
      logic [11:0]        code [WHEELS];
      logic [15:0]        yaw_rel, heading, dyaw;
      longint             c, s, vx, vy, sum_px, sum_py, sum_vx, sum_vy;
      longint             len, wid;
      rsp_type            r;
      spd = '{t.speed_0, t.speed_1, t.speed_2, t.speed_3};
      code = '{t.steer_0, t.steer_1, t.steer_2, t.steer_3};
      sum_px = 0; sum_py = 0; sum_vx = 0; sum_vy = 0;
      if (!zero_taken) begin
         // First tick after reset: latch the yaw zero and place the corners.
         yaw_zero = t.yaw_sample;
         zero_taken = 1;
         len = longint'(settings.half_length);
         wid = longint'(settings.half_width);
         for (int i = 0; i < WHEELS; i++) begin
            corner_x[i] = (i == 0 || i == 3) ? len[31:0] : -len[31:0];
            corner_y[i] = (i < 2) ? wid[31:0] : -wid[31:0];
         end
      end
      yaw_rel = t.yaw_sample - yaw_zero;
      for (int i = 0; i < WHEELS; i++) begin
         heading = {code[i] - 12'd2048, 4'b0000} + yaw_rel;
         rotate_heading(int'($signed(heading)), c, s);
         vx = (longint'(spd[i]) * c * longint'(settings.speed_scale)) >>> 24;
         vy = (longint'(spd[i]) * s * longint'(settings.speed_scale)) >>> 24;
         corner_x[i] = clamp32(longint'(corner_x[i])
                               + ((vx * longint'(settings.step_time)) >>> 16));
         corner_y[i] = clamp32(longint'(corner_y[i])
                               + ((vy * longint'(settings.step_time)) >>> 16));
         sum_px += corner_x[i];
         sum_py += corner_y[i];
         sum_vx += vx;
         sum_vy += vy;
      end
      dyaw = yaw_rel - last_yaw;
      last_yaw = yaw_rel;
      r.pos_x = clamp32(sum_px / WHEELS);
      r.pos_y = clamp32(sum_py / WHEELS);
      r.vel_x = clamp32(sum_vx / WHEELS);
      r.vel_y = clamp32(sum_vy / WHEELS);
      r.yaw_out = yaw_rel;
      r.angular_rate = clamp32(longint'($signed(dyaw))
                               * longint'(settings.inverse_step_time));
      return r;
   endfunction

   task automatic report_field(input string name, input longint want, input longint got);
      if (want != got) begin
         fail_count++;
         $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name,
                  want, got);
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         settings <= '{SPEED_SCALE_RST, STEP_TIME_RST, INV_STEP_RST,
                       HALF_LENGTH_RST, HALF_WIDTH_RST};
         yaw_zero = '0;
         last_yaw = '0;
         zero_taken = 0;
         pending_odometry.delete();
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               CSR_SPEED_SCALE: settings.speed_scale <= csr_wdata[15:0];
               CSR_STEP_TIME:   settings.step_time <= csr_wdata[15:0];
               CSR_INV_STEP:    settings.inverse_step_time <= csr_wdata[15:0];
               CSR_HALF_LENGTH: settings.half_length <= csr_wdata;
               CSR_HALF_WIDTH:  settings.half_width <= csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            pending_odometry.push_back(advance_odometry(req_data));
         if (rsp_valid && rsp_ready) begin
            checked_count++;
            if (pending_odometry.size() == 0) begin
               fail_count++;
               $display("%0t ns: unexpected result, expected none, actual %p", $time,
                        rsp_data);
            end else begin
               want = pending_odometry.pop_front();
               report_field("pos_x", want.pos_x, rsp_data.pos_x);
               report_field("pos_y", want.pos_y, rsp_data.pos_y);
               report_field("vel_x", want.vel_x, rsp_data.vel_x);
               report_field("vel_y", want.vel_y, rsp_data.vel_y);
               report_field("yaw_out", want.yaw_out, rsp_data.yaw_out);
               report_field("angular_rate", want.angular_rate, rsp_data.angular_rate);
            end
         end
      end
   end

   initial begin
      fail_count = 0;
      checked_count = 0;
   end

endmodule

### tb/sv/swerve_wheel_odometry_core_tb.sv
// ----------------------------------------------------------------------------
// swerve_wheel_odometry_core_tb
// Stimulus and verdict for the swerve wheel odometry core.
// ----------------------------------------------------------------------------
// A short directed run covers field extremes and the first-tick zeroing, then
// phases of random ticks under changing settings follow, including long
// straight surges that drive the wheel positions into saturation both ways.
// The checker beside the core predicts and compares every result.
// ----------------------------------------------------------------------------
module swerve_wheel_odometry_core_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import swodo_pkg::*;

   // Generous bound on the run, allowing for the rare long gaps.
   localparam int CYCLE_LIMIT = 3_000_000;
   // Cycles let pass before a settings write once the results have drained.
   localparam int SETTLE_CYCLES = 150;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   req_type                  req_data = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   rsp_type                  rsp_data;
   logic                     csr_write_enable = 1'b0;
   logic [CSR_IDX_BITS-1:0]  csr_index = CSR_SPEED_SCALE;
   logic [CSR_DATA_BITS-1:0] csr_wdata = '0;

   int       fail_count, outstanding, checked_count;
   int       cycle_count = 0;
   int       ticks_sent = 0;
   int       setting_sets = 0;
   bit       quiet = 0;          // no idling on either side while set
   logic [15:0] yaw_base;        // yaw of the first tick, i.e. the zero heading
   logic [15:0] yaw_walk;

   swerve_wheel_odometry_core DUT (
      .clock, .reset, .req_valid, .req_ready, .req_data, .rsp_valid, .rsp_ready,
      .rsp_data, .csr_write_enable, .csr_index, .csr_wdata
   );

   swerve_wheel_odometry_checker odometry_checker (
      .clock, .reset, .req_valid, .req_ready, .req_data, .rsp_valid, .rsp_ready,
      .rsp_data, .csr_write_enable, .csr_index, .csr_wdata, .fail_count,
      .outstanding, .checked_count
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Run stopped at the cycle limit with %0d results pending.", outstanding);
         $display("FAILED: results differ");
         $finish;
      end
   end

   // Mostly short gaps, now and then a long one.
   function automatic int idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 15);
      return $urandom_range(30, 150);
   endfunction

   // The result side alternates ready stretches with stalls.
   initial begin
      int stall;
      @(negedge reset);
      forever begin
         stall = idle_length();
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   end

   // Holds valid until the transaction is accepted; valid stays high when the
   // next tick follows with no gap.
   task automatic send_tick(input req_type t);
      int gap;
      gap = idle_length();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= t;
      do @(posedge clock); while (!req_ready);
      ticks_sent++;
   endtask

   // Waits for every result, then lets the core go quiet before a write.
   task automatic drain_core();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes all five settings plus one unused index, enable lowered once.
   task automatic program_settings(input logic [19:0] scale, input logic [19:0] step,
                                   input logic [19:0] inv, input logic [19:0] hlen,
                                   input logic [19:0] hwid);
      logic [19:0] vals [5];
      logic [CSR_IDX_BITS-1:0] idx [5];
      vals = '{scale, step, inv, hlen, hwid};
      idx = '{CSR_SPEED_SCALE, CSR_STEP_TIME, CSR_INV_STEP, CSR_HALF_LENGTH,
              CSR_HALF_WIDTH};
      for (int i = 0; i < 5; i++) begin
         csr_write_enable <= 1'b1;
         csr_index <= idx[i];
         csr_wdata <= vals[i];
         @(posedge clock);
      end
      // An index past the last register must change nothing.
      csr_index <= CSR_IDX_BITS'($urandom_range(5, 7));
      csr_wdata <= 20'($urandom);
      @(posedge clock);
      csr_write_enable <= 1'b0;
      setting_sets++;
   endtask

   function automatic logic [11:0] pick_steer();
      case ($urandom_range(0, 7))
         0: return 12'd0;
         1: return 12'd4095;
         2: return 12'd2048;
         default: return 12'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] pick_speed();
      case ($urandom_range(0, 9))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return 16'($urandom_range(0, 512) - 256);
         default: return 16'($urandom);
      endcase
   endfunction

   // surge: 0 free driving, 1 full speed ahead, 2 full speed reverse.
   function automatic req_type make_tick(input int surge);
      req_type t;
      logic [15:0] s [4];
      if (surge == 0) begin
         for (int i = 0; i < 4; i++) s[i] = pick_speed();
         t.steer_0 = pick_steer(); t.steer_1 = pick_steer();
         t.steer_2 = pick_steer(); t.steer_3 = pick_steer();
         if ($urandom_range(0, 9) == 0) yaw_walk = 16'($urandom);
         else yaw_walk = yaw_walk + 16'($urandom_range(0, 800) - 400);
         t.yaw_sample = yaw_walk;
      end else begin
         for (int i = 0; i < 4; i++)
            s[i] = (surge == 1) ? 16'($urandom_range(30000, 32767))
                                : 16'(-$urandom_range(30000, 32768));
         t.steer_0 = 12'($urandom_range(2040, 2056));
         t.steer_1 = 12'($urandom_range(2040, 2056));
         t.steer_2 = 12'($urandom_range(2040, 2056));
         t.steer_3 = 12'($urandom_range(2040, 2056));
         t.yaw_sample = yaw_base + 16'($urandom_range(0, 64) - 32);
      end
      t.speed_0 = s[0]; t.speed_1 = s[1]; t.speed_2 = s[2]; t.speed_3 = s[3];
      return t;
   endfunction

   initial begin
      req_type t;
      int      surge, count;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Corners take the largest length and a zero width on the first tick.
      program_settings(20'hFFFFF, 20'h0FFFF, 20'hFFFFF, 20'hFFFFF, 20'h00000);

      // Directed part: first tick latches a yaw of minus half a turn.
      yaw_base = 16'h8000;
      t = '{16'h7FFF, 16'h8000, 16'h0000, 16'h0001, 12'd0, 12'd4095, 12'd2048,
            12'd1, 16'h8000};
      send_tick(t);
      t = '{16'h8000, 16'h7FFF, 16'hFFFF, 16'h0100, 12'd2048, 12'd2048, 12'd2048,
            12'd2048, 16'h7FFF};
      send_tick(t);
      t.yaw_sample = 16'h8000;   // largest negative yaw sample
      send_tick(t);
      t.yaw_sample = 16'h7FFF;   // largest positive yaw sample
      send_tick(t);
      for (int k = 0; k < 16; k++) begin
         // Sweep the steering in sixteenth and thirty-second turns, both ways.
         t.steer_0 = 12'(k * 256);
         t.steer_1 = 12'(4095 - k * 256);
         t.steer_2 = 12'(2048 + k * 128);
         t.steer_3 = 12'(k * 273);
         t.speed_0 = (k % 2) ? 16'h7FFF : 16'h8000;
         t.yaw_sample = 16'(k * 4096);
         send_tick(t);
      end
      yaw_walk = 16'h8000;

      // Random phases under changing settings.
      for (int ph = 0; ph < 12; ph++) begin
         drain_core();
         surge = 0;
         count = 100;
         quiet = (ph % 4 == 1);
         case (ph)
            0: program_settings('0, '0, '0, '0, '0);
            1: program_settings(20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF);
            2: begin
               program_settings(20'h0FFFF, 20'h0FFFF, 20'($urandom), 20'($urandom),
                                20'($urandom));
               surge = 1;
               count = 280;
            end
            3: begin
               program_settings(20'h0FFFF, 20'h0FFFF, 20'($urandom), 20'($urandom),
                                20'($urandom));
               surge = 2;
               count = 560;
            end
            default: program_settings(20'($urandom), 20'($urandom_range(0, 4000)),
                                      20'($urandom), 20'($urandom), 20'($urandom));
         endcase
         for (int k = 0; k < count; k++) begin
            // Surge phases still mix in some free driving.
            send_tick(make_tick(($urandom_range(0, 19) == 0) ? 0 : surge));
         end
      end

      quiet = 0;
      drain_core();
      $display("Sent %0d ticks and checked %0d results over %0d setting sets,",
               ticks_sent, checked_count, setting_sets);
      $display("including zero and full-scale settings and saturating surges both ways.");
      if (fail_count == 0 && outstanding == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
